### sv/iat_pkg.sv
`default_nettype none
package iat_pkg;

  localparam int SPAN_LIMIT_DEF = 10;

  localparam logic [2:0] CLS_ALU   = 3'h4;
  localparam logic [2:0] CLS_ALU64 = 3'h7;

  localparam logic [3:0] OP_ADD  = 4'h0;
  localparam logic [3:0] OP_SUB  = 4'h1;
  localparam logic [3:0] OP_MUL  = 4'h2;
  localparam logic [3:0] OP_DIV  = 4'h3;
  localparam logic [3:0] OP_OR   = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LSH  = 4'h6;
  localparam logic [3:0] OP_RSH  = 4'h7;
  localparam logic [3:0] OP_NEG  = 4'h8;
  localparam logic [3:0] OP_MOD  = 4'h9;
  localparam logic [3:0] OP_XOR  = 4'hA;
  localparam logic [3:0] OP_MOV  = 4'hB;
  localparam logic [3:0] OP_ARSH = 4'hC;
  localparam logic [3:0] OP_END  = 4'hD;

  localparam logic [2:0] K_NOINIT  = 3'd0;
  localparam logic [2:0] K_NUM     = 3'd1;
  localparam logic [2:0] K_UNKNOWN = 3'd2;
  localparam logic [2:0] K_BOT     = 3'd3;

  function automatic logic op_supported(input logic [7:0] op);
    logic ok;
    ok = 1'b0;
    if (op[2:0] == CLS_ALU || op[2:0] == CLS_ALU64) begin
      if (op[7:4] == OP_NEG) ok = !op[3];
      else if (op[7:4] == OP_END) ok = (op[2:0] == CLS_ALU);
      else ok = (op[7:4] <= OP_ARSH);
    end
    return ok;
  endfunction

  function automatic logic reads_src(input logic [7:0] op);
    return op[3] && op[7:4] != OP_NEG && op[7:4] != OP_END;
  endfunction

  function automatic logic corner_bounded(input logic [3:0] code);
    return code <= OP_MUL || code == OP_OR || code == OP_AND || code == OP_LSH
        || code == OP_RSH || code == OP_ARSH;
  endfunction

  function automatic logic [2:0] result_kind(input logic [7:0] op, input logic [2:0] dk,
                                             input logic [2:0] sk);
    logic rg;
    logic [2:0] k;
    rg = reads_src(op);
    if (rg && sk == K_NOINIT) k = K_BOT;
    else if (dk == K_NOINIT) k = K_BOT;
    else if (dk == K_UNKNOWN) k = K_UNKNOWN;
    else if (!rg && (op[7:4] == OP_ADD || op[7:4] == OP_SUB)) k = dk;
    else if (rg && op[7:4] == OP_ADD) begin
      if (dk == K_NUM && sk == K_NUM) k = K_NUM;
      else if (sk == K_NUM) k = dk;
      else if (dk == K_NUM) k = sk;
      else k = K_UNKNOWN;
    end else if (rg && op[7:4] == OP_SUB) k = (sk == dk) ? K_NUM : K_UNKNOWN;
    else k = (dk == K_NUM && (!rg || sk == K_NUM)) ? K_NUM : K_UNKNOWN;
    return k;
  endfunction

endpackage
`default_nettype wire

### sv/iat_eval.sv
`default_nettype none
module iat_eval (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [7:0]  op,
  input  wire logic [63:0] ix,
  input  wire logic [63:0] d,
  input  wire logic [63:0] s,
  output logic             fin,
  output logic [63:0]      r
);

  logic        run;
  logic [7:0]  op_r;
  logic [63:0] ix_r;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] acc;
  logic [6:0]  cnt;

  logic        is64;
  logic [3:0]  code;
  logic [63:0] bsel;
  logic [5:0]  sh;
  logic [64:0] rem_sh;
  logic        ge;
  logic [63:0] one_v;
  logic [63:0] sw64;
  logic [31:0] ar32;

  assign is64   = (op_r[2:0] == iat_pkg::CLS_ALU64);
  assign code   = op_r[7:4];
  assign bsel   = op[3] ? s : ix;
  assign sh     = is64 ? b[5:0] : {1'b0, b[4:0]};
  assign rem_sh = {acc, a[63]};
  assign ge     = (rem_sh >= {1'b0, b});
  assign sw64   = {a[7:0], a[15:8], a[23:16], a[31:24],
                   a[39:32], a[47:40], a[55:48], a[63:56]};
  assign ar32   = $signed(a[31:0]) >>> sh[4:0];

  function automatic logic [63:0] fmask(input logic w64, input logic [63:0] v);
    return w64 ? v : {32'b0, v[31:0]};
  endfunction

  always_comb begin
    case (code)
      iat_pkg::OP_ADD:  one_v = a + b;
      iat_pkg::OP_SUB:  one_v = a - b;
      iat_pkg::OP_OR:   one_v = a | b;
      iat_pkg::OP_AND:  one_v = a & b;
      iat_pkg::OP_LSH:  one_v = a << sh;
      iat_pkg::OP_RSH:  one_v = a >> sh;
      iat_pkg::OP_NEG:  one_v = 64'd0 - a;
      iat_pkg::OP_XOR:  one_v = a ^ b;
      iat_pkg::OP_ARSH: one_v = is64 ? 64'($signed(a) >>> sh) : {32'b0, ar32};
      iat_pkg::OP_END: begin
        if (ix_r == 64'd16) one_v = op_r[3] ? {48'b0, a[7:0], a[15:8]} : {48'b0, a[15:0]};
        else if (ix_r == 64'd32)
          one_v = op_r[3] ? {32'b0, a[7:0], a[15:8], a[23:16], a[31:24]} : {32'b0, a[31:0]};
        else if (ix_r == 64'd64) one_v = op_r[3] ? sw64 : a;
        else one_v = a;
      end
      default: one_v = a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        op_r <= op;
        ix_r <= ix;
        if (op[7:4] == iat_pkg::OP_END || op[2:0] == iat_pkg::CLS_ALU64) a <= d;
        else a <= {32'b0, d[31:0]};
        b   <= (op[2:0] == iat_pkg::CLS_ALU64) ? bsel : {32'b0, bsel[31:0]};
        acc <= 64'd0;
        cnt <= 7'd0;
        run <= 1'b1;
      end else if (run) begin
        if (code == iat_pkg::OP_MUL) begin
          if (cnt == 7'd64) begin
            r   <= fmask(is64, acc);
            fin <= 1'b1;
            run <= 1'b0;
          end else begin
            if (b[0]) acc <= acc + a;
            a   <= a << 1;
            b   <= b >> 1;
            cnt <= cnt + 7'd1;
          end
        end else if (code == iat_pkg::OP_DIV || code == iat_pkg::OP_MOD) begin
          if (cnt == 7'd64) begin
            if (code == iat_pkg::OP_DIV) r <= (b == 64'd0) ? 64'd0 : fmask(is64, a);
            else r <= fmask(is64, acc);
            fin <= 1'b1;
            run <= 1'b0;
          end else begin
            acc <= ge ? 64'(rem_sh - {1'b0, b}) : rem_sh[63:0];
            a   <= {a[62:0], ge};
            cnt <= cnt + 7'd1;
          end
        end else begin
          r   <= (code == iat_pkg::OP_END) ? one_v : fmask(is64, one_v);
          fin <= 1'b1;
          run <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

### sv/interval_alu_transfer.sv
// channel   signals                                                 transaction
// command   start, busy, op, imm, dst_kind/low/high, src_kind/low/high  start & !busy
// result    done, res_kind, res_low, res_high, bad_op               done, one cycle
//
// one transaction at a time; busy is high from acceptance until the done cycle
// bad opcodes, moves and pass-through kinds: done directly after the decode state
// evaluations run on one shared unit, which iterates bit by bit for mul, div and mod
// up to 4 corner evaluations, then up to (SPAN_LIMIT+1)^2 sweep evaluations
// reset clears the sequencer; the result strobe cannot be stalled
`default_nettype none
module interval_alu_transfer #(
  parameter int SPAN_LIMIT = iat_pkg::SPAN_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  op,
  input  wire logic signed [31:0] imm,
  input  wire logic [2:0]  dst_kind,
  input  wire logic [63:0] dst_low,
  input  wire logic [63:0] dst_high,
  input  wire logic [2:0]  src_kind,
  input  wire logic [63:0] src_low,
  input  wire logic [63:0] src_high,
  output logic             done,
  output logic [2:0]       res_kind,
  output logic [63:0]      res_low,
  output logic [63:0]      res_high,
  output logic             bad_op
);

  localparam int SW = $clog2(SPAN_LIMIT + 2);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DEC   = 13'b0000000000010,
    S_CISS  = 13'b0000000000100,
    S_CWAIT = 13'b0000000001000,
    S_NRES  = 13'b0000000010000,
    S_CMP   = 13'b0000000100000,
    S_CHK   = 13'b0000001000000,
    S_SCHK  = 13'b0000010000000,
    S_SISS  = 13'b0000100000000,
    S_SWAIT = 13'b0001000000000,
    S_SEND  = 13'b0010000000000,
    S_DONE  = 13'b0100000000000,
    S_SPARE = 13'b1000000000000
  } state_t;

  state_t state;

  logic [7:0]    op_r;
  logic [63:0]   ix_r;
  logic [2:0]    dk;
  logic [2:0]    sk;
  logic [63:0]   dlo, dhi, slo, shi;
  logic [2:0]    kind;
  logic          narrow;
  logic          sweep_ok;
  logic [SW-1:0] dspan, sspan, i, j;
  logic [1:0]    ci;
  logic [63:0]   c [4];
  logic [63:0]   lmin, lmax, hmin, hmax;
  logic [63:0]   tmin, tmax;

  logic [63:0]   dsp, ssp;
  logic [2:0]    kind_c;
  logic          ev_start, ev_fin;
  logic [63:0]   ev_d, ev_s, ev_r;

  assign dsp    = dhi - dlo;
  assign ssp    = shi - slo;
  assign kind_c = iat_pkg::result_kind(op_r, dk, sk);
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);

  assign ev_start = (state == S_CISS) || (state == S_SISS);
  assign ev_d = (state == S_SISS) ? dlo + 64'(i) : (ci[1] ? dhi : dlo);
  assign ev_s = (state == S_SISS) ? slo + 64'(j) : (ci[0] ? shi : slo);

  iat_eval u_eval (
    .clk   (clk),
    .rst   (rst),
    .start (ev_start),
    .op    (op_r),
    .ix    (ix_r),
    .d     (ev_d),
    .s     (ev_s),
    .fin   (ev_fin),
    .r     (ev_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r  <= op;
            ix_r  <= 64'(imm);
            dk    <= dst_kind;
            sk    <= src_kind;
            dlo   <= dst_low;
            dhi   <= dst_high;
            slo   <= src_low;
            shi   <= src_high;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          bad_op   <= !iat_pkg::op_supported(op_r);
          kind     <= kind_c;
          ci       <= 2'd0;
          sweep_ok <= (dlo <= dhi) && (slo <= shi) && (dsp <= 64'(SPAN_LIMIT))
                   && (ssp <= 64'(SPAN_LIMIT));
          dspan    <= dsp[SW-1:0];
          sspan    <= ssp[SW-1:0];
          if (!iat_pkg::op_supported(op_r)) begin
            res_kind <= iat_pkg::K_NOINIT;
            res_low  <= 64'd0;
            res_high <= 64'd0;
            state    <= S_DONE;
          end else if (op_r[7:4] == iat_pkg::OP_MOV) begin
            res_kind <= op_r[3] ? sk : iat_pkg::K_NUM;
            res_low  <= op_r[3] ? slo : ix_r;
            res_high <= op_r[3] ? shi : ix_r;
            state    <= S_DONE;
          end else if (kind_c == iat_pkg::K_UNKNOWN || kind_c == iat_pkg::K_NOINIT
                       || kind_c == iat_pkg::K_BOT) begin
            res_kind <= kind_c;
            res_low  <= dlo;
            res_high <= dhi;
            state    <= S_DONE;
          end else if (dsp <= 64'd1 && op_r[2:0] == iat_pkg::CLS_ALU
                       && op_r[7:4] != iat_pkg::OP_NEG) begin
            narrow <= 1'b1;
            state  <= S_CISS;
          end else if (iat_pkg::corner_bounded(op_r[7:4])) begin
            narrow <= 1'b0;
            state  <= S_CISS;
          end else begin
            state <= S_SCHK;
          end
        end
        S_CISS: state <= S_CWAIT;
        S_CWAIT: begin
          if (ev_fin) begin
            c[ci] <= ev_r;
            if (narrow) begin
              if (ci == 2'd0) begin
                ci    <= 2'd3;
                state <= S_CISS;
              end else begin
                state <= S_NRES;
              end
            end else if (ci == 2'd3) begin
              state <= S_CMP;
            end else begin
              ci    <= ci + 2'd1;
              state <= S_CISS;
            end
          end
        end
        S_NRES: begin
          res_kind <= kind;
          res_low  <= (c[0] < c[3]) ? c[0] : c[3];
          res_high <= (c[0] > c[3]) ? c[0] : c[3];
          state    <= S_DONE;
        end
        S_CMP: begin
          lmin  <= (c[0] < c[1]) ? c[0] : c[1];
          lmax  <= (c[0] > c[1]) ? c[0] : c[1];
          hmin  <= (c[2] < c[3]) ? c[2] : c[3];
          hmax  <= (c[2] > c[3]) ? c[2] : c[3];
          state <= S_CHK;
        end
        S_CHK: begin
          if (lmax <= hmin) begin
            res_kind <= kind;
            res_low  <= lmin;
            res_high <= hmax;
            state    <= S_DONE;
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          i    <= '0;
          j    <= '0;
          tmin <= '1;
          tmax <= '0;
          if (sweep_ok) begin
            state <= S_SISS;
          end else begin
            res_kind <= kind;
            res_low  <= 64'd0;
            res_high <= '1;
            state    <= S_DONE;
          end
        end
        S_SISS: state <= S_SWAIT;
        S_SWAIT: begin
          if (ev_fin) begin
            if (ev_r < tmin) tmin <= ev_r;
            if (ev_r > tmax) tmax <= ev_r;
            if (j == sspan) begin
              j <= '0;
              if (i == dspan) begin
                state <= S_SEND;
              end else begin
                i     <= i + 1'b1;
                state <= S_SISS;
              end
            end else begin
              j     <= j + 1'b1;
              state <= S_SISS;
            end
          end
        end
        S_SEND: begin
          res_kind <= kind;
          res_low  <= tmin;
          res_high <= tmax;
          state    <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted transaction did not raise busy");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after result");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && bad_op |-> res_kind == iat_pkg::K_NOINIT && res_low == 64'd0 && res_high == 64'd0)
    else $error("bad opcode result not cleared");

  a_eval_idle: assert property (@(posedge clk) disable iff (rst)
    ev_start |-> busy)
    else $error("evaluation issued while idle");

endmodule
`default_nettype wire

### sim/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        bad;
  } ivl_res_t;

  localparam logic [63:0] M32 = 64'h0000_0000_ffff_ffff;
  localparam logic [63:0] ALL1 = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [7:0] op = '0;
  logic signed [31:0] imm = '0;
  logic [2:0] dst_kind = '0, src_kind = '0;
  logic [63:0] dst_low = '0, dst_high = '0, src_low = '0, src_high = '0;
  logic done;
  logic [2:0] res_kind;
  logic [63:0] res_low, res_high;
  logic bad_op;

  ivl_res_t pending_q[$];
  int n_sent, n_checked, n_errors, n_bad_sent;

  always #10 clk = ~clk;

  interval_alu_transfer uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .imm(imm),
    .dst_kind(dst_kind), .dst_low(dst_low), .dst_high(dst_high),
    .src_kind(src_kind), .src_low(src_low), .src_high(src_high),
    .done(done), .res_kind(res_kind), .res_low(res_low), .res_high(res_high),
    .bad_op(bad_op)
  );

  // ---------------- predictor ----------------
  function automatic logic legal_op(input logic [7:0] o);
    if (o[2:0] != iat_pkg::CLS_ALU && o[2:0] != iat_pkg::CLS_ALU64) return 1'b0;
    if (o[7:4] == iat_pkg::OP_NEG) return !o[3];
    if (o[7:4] == iat_pkg::OP_END) return o[2:0] == iat_pkg::CLS_ALU;
    return o[7:4] <= iat_pkg::OP_ARSH;
  endfunction

  function automatic logic uses_src(input logic [7:0] o);
    return o[3] && o[7:4] != iat_pkg::OP_NEG && o[7:4] != iat_pkg::OP_END;
  endfunction

  function automatic logic [63:0] swap_bytes(input logic [63:0] v, input int nbytes);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < nbytes; k++) r[8*k +: 8] = v[8*(nbytes-1-k) +: 8];
    return r;
  endfunction

  function automatic logic [31:0] swap_width(input int k);
    case (k)
      0: return 32'd16;
      1: return 32'd32;
      2: return 32'd64;
      default: return 32'd8;
    endcase
  endfunction

  function automatic logic [63:0] alu_value(input logic [7:0] o, input logic [63:0] d,
                                            input logic [63:0] s, input logic [63:0] ix);
    logic wide;
    logic [63:0] b, r;
    logic [5:0] sh;
    wide = (o[2:0] == iat_pkg::CLS_ALU64);
    b = o[3] ? s : ix;
    if (o[7:4] == iat_pkg::OP_END) begin
      if (ix == 64'd16) return o[3] ? swap_bytes(d, 2) : (d & 64'hffff);
      if (ix == 64'd32) return o[3] ? swap_bytes(d, 4) : (d & M32);
      if (ix == 64'd64) return o[3] ? swap_bytes(d, 8) : d;
      return d;
    end
    if (!wide) begin
      d &= M32;
      b &= M32;
    end
    sh = wide ? b[5:0] : {1'b0, b[4:0]};
    case (o[7:4])
      iat_pkg::OP_ADD:  r = d + b;
      iat_pkg::OP_SUB:  r = d - b;
      iat_pkg::OP_MUL:  r = d * b;
      iat_pkg::OP_DIV:  r = (b == 0) ? 64'd0 : d / b;
      iat_pkg::OP_OR:   r = d | b;
      iat_pkg::OP_AND:  r = d & b;
      iat_pkg::OP_LSH:  r = d << sh;
      iat_pkg::OP_RSH:  r = d >> sh;
      iat_pkg::OP_NEG:  r = 64'd0 - d;
      iat_pkg::OP_MOD:  r = (b == 0) ? d : d % b;
      iat_pkg::OP_XOR:  r = d ^ b;
      iat_pkg::OP_ARSH:
        r = wide ? 64'($signed(d) >>> sh) : {32'd0, 32'($signed(d[31:0]) >>> sh)};
      default: r = d;
    endcase
    return wide ? r : (r & M32);
  endfunction

  function automatic logic [2:0] kind_of(input logic [7:0] o, input logic [2:0] dk,
                                         input logic [2:0] sk);
    logic rg;
    logic [3:0] c;
    rg = uses_src(o);
    c = o[7:4];
    if (rg && sk == iat_pkg::K_NOINIT) return iat_pkg::K_BOT;
    if (dk == iat_pkg::K_NOINIT) return iat_pkg::K_BOT;
    if (dk == iat_pkg::K_UNKNOWN) return iat_pkg::K_UNKNOWN;
    if (!rg && (c == iat_pkg::OP_ADD || c == iat_pkg::OP_SUB)) return dk;
    if (rg && c == iat_pkg::OP_ADD) begin
      if (dk == iat_pkg::K_NUM && sk == iat_pkg::K_NUM) return iat_pkg::K_NUM;
      if (sk == iat_pkg::K_NUM) return dk;
      if (dk == iat_pkg::K_NUM) return sk;
      return iat_pkg::K_UNKNOWN;
    end
    if (rg && c == iat_pkg::OP_SUB) return (sk == dk) ? iat_pkg::K_NUM : iat_pkg::K_UNKNOWN;
    return (dk == iat_pkg::K_NUM && (!rg || sk == iat_pkg::K_NUM))
           ? iat_pkg::K_NUM : iat_pkg::K_UNKNOWN;
  endfunction

  function automatic ivl_res_t transfer(input logic [7:0] o, input logic [31:0] im,
                                        input logic [2:0] dk, input logic [63:0] dlo,
                                        input logic [63:0] dhi, input logic [2:0] sk,
                                        input logic [63:0] slo, input logic [63:0] shi);
    ivl_res_t r;
    logic [63:0] ix, a1, a2, b1, b2, t, tmin, tmax;
    logic [3:0] c;
    logic found;
    ix = {{32{im[31]}}, im};
    c = o[7:4];
    r = '0;
    if (!legal_op(o)) begin
      r.bad = 1'b1;
      return r;
    end
    if (c == iat_pkg::OP_MOV) begin
      if (o[3]) r = '{sk, slo, shi, 1'b0};
      else r = '{iat_pkg::K_NUM, ix, ix, 1'b0};
      return r;
    end
    r.kind = kind_of(o, dk, sk);
    r.lo = dlo;
    r.hi = dhi;
    if (r.kind == iat_pkg::K_UNKNOWN || r.kind == iat_pkg::K_NOINIT
        || r.kind == iat_pkg::K_BOT) return r;
    if (dhi - dlo <= 1 && o[2:0] == iat_pkg::CLS_ALU && c != iat_pkg::OP_NEG) begin
      a1 = alu_value(o, dlo, slo, ix);
      b1 = alu_value(o, dhi, shi, ix);
      r.lo = (a1 < b1) ? a1 : b1;
      r.hi = (a1 > b1) ? a1 : b1;
      return r;
    end
    found = 1'b0;
    if (c <= iat_pkg::OP_MUL || c == iat_pkg::OP_OR || c == iat_pkg::OP_AND
        || c == iat_pkg::OP_LSH || c == iat_pkg::OP_RSH || c == iat_pkg::OP_ARSH) begin
      a1 = alu_value(o, dlo, slo, ix);
      a2 = alu_value(o, dlo, shi, ix);
      b1 = alu_value(o, dhi, slo, ix);
      b2 = alu_value(o, dhi, shi, ix);
      if (((a1 > a2) ? a1 : a2) <= ((b1 < b2) ? b1 : b2)) begin
        r.lo = (a1 < a2) ? a1 : a2;
        r.hi = (b1 > b2) ? b1 : b2;
        found = 1'b1;
      end
    end
    if (!found && dlo <= dhi && slo <= shi && dhi - dlo <= 64'(iat_pkg::SPAN_LIMIT_DEF)
        && shi - slo <= 64'(iat_pkg::SPAN_LIMIT_DEF)) begin
      tmin = ALL1;
      tmax = '0;
      for (logic [63:0] i = 0; i <= dhi - dlo; i++)
        for (logic [63:0] j = 0; j <= shi - slo; j++) begin
          t = alu_value(o, dlo + i, slo + j, ix);
          if (t < tmin) tmin = t;
          if (t > tmax) tmax = t;
        end
      r.lo = tmin;
      r.hi = tmax;
      found = 1'b1;
    end
    if (!found) begin
      r.lo = '0;
      r.hi = ALL1;
    end
    return r;
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    ivl_res_t want;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("result with no transaction outstanding");
        n_errors++;
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (res_kind !== want.kind) begin
          $error("res_kind expected %0d actual %0d", want.kind, res_kind);
          n_errors++;
        end
        if (res_low !== want.lo) begin
          $error("res_low expected %h actual %h", want.lo, res_low);
          n_errors++;
        end
        if (res_high !== want.hi) begin
          $error("res_high expected %h actual %h", want.hi, res_high);
          n_errors++;
        end
        if (bad_op !== want.bad) begin
          $error("bad_op expected %0d actual %0d", want.bad, bad_op);
          n_errors++;
        end
      end
    end
  end

  // ---------------- driver ----------------
  task automatic idle_gap();
    int g, p;
    p = $urandom_range(0, 99);
    if (p < 55) g = 0;
    else if (p < 90) g = $urandom_range(1, 3);
    else g = $urandom_range(5, 40);
    repeat (g) @(negedge clk);
  endtask

  task automatic send_cmd(input logic [7:0] o, input logic [31:0] im, input logic [2:0] dk,
                          input logic [63:0] dlo, input logic [63:0] dhi,
                          input logic [2:0] sk, input logic [63:0] slo,
                          input logic [63:0] shi);
    op = o;
    imm = im;
    dst_kind = dk;
    dst_low = dlo;
    dst_high = dhi;
    src_kind = sk;
    src_low = slo;
    src_high = shi;
    start = 1'b1;
    do @(posedge clk); while (busy);
    pending_q.push_back(transfer(o, im, dk, dlo, dhi, sk, slo, shi));
    n_sent++;
    if (!legal_op(o)) n_bad_sent++;
    @(negedge clk);
    start = 1'b0;
    idle_gap();
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] rnd_op();
    logic [7:0] o;
    if ($urandom_range(0, 9) == 0) return 8'($urandom());
    o = {4'($urandom_range(0, 13)), 1'($urandom()),
         $urandom_range(0, 1) ? iat_pkg::CLS_ALU : iat_pkg::CLS_ALU64};
    if (o[7:4] == iat_pkg::OP_NEG) o[3] = 1'b0;
    if (o[7:4] == iat_pkg::OP_END) o[2:0] = iat_pkg::CLS_ALU;
    return o;
  endfunction

  task automatic rnd_interval(output logic [63:0] lo, output logic [63:0] hi,
                              input int maxspan);
    case ($urandom_range(0, 6))
      0: lo = 64'($urandom_range(0, 20));
      1: lo = rnd64();
      2: lo = ALL1 - 64'($urandom_range(0, 15));
      3: lo = {32'd0, $urandom()};
      4: lo = 64'h0000_0000_7fff_fff8 + 64'($urandom_range(0, 15));
      5: lo = 64'h7fff_ffff_ffff_fff8 + 64'($urandom_range(0, 15));
      default: begin
        lo = rnd64();
        hi = rnd64();
        return;
      end
    endcase
    hi = lo + 64'($urandom_range(0, maxspan));
  endtask

  function automatic logic [31:0] rnd_imm();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'(-$urandom_range(1, 70));
      2: return swap_width($urandom_range(0, 2));
      default: return $urandom_range(0, 70);
    endcase
  endfunction

  // ---------------- tests ----------------
  task automatic test_every_opcode();
    for (int c = 0; c < 14; c++)
      for (int s = 0; s < 2; s++)
        send_cmd({4'(c), 1'(s), iat_pkg::CLS_ALU}, 32'd3, iat_pkg::K_NUM, 64'd5, 64'd9,
                 iat_pkg::K_NUM, 64'd1, 64'd4);
  endtask

  task automatic test_bad_opcodes();
    send_cmd({iat_pkg::OP_NEG, 1'b1, iat_pkg::CLS_ALU}, 0, iat_pkg::K_NUM, 1, 2,
             iat_pkg::K_NUM, 3, 4);
    send_cmd({iat_pkg::OP_END, 1'b0, iat_pkg::CLS_ALU64}, 16, iat_pkg::K_NUM, 1, 2,
             iat_pkg::K_NUM, 3, 4);
    send_cmd(8'he4, 0, iat_pkg::K_NUM, 1, 2, iat_pkg::K_NUM, 3, 4);
    send_cmd(8'hf7, 0, iat_pkg::K_NUM, 1, 2, iat_pkg::K_NUM, 3, 4);
    send_cmd(8'h00, 0, iat_pkg::K_NUM, 1, 2, iat_pkg::K_NUM, 3, 4);
  endtask

  task automatic test_special_cases();
    // moves, kinds, narrow, full range
    send_cmd({iat_pkg::OP_MOV, 1'b1, iat_pkg::CLS_ALU64}, 0, iat_pkg::K_BOT, 0, 1, 3'd6,
             ALL1, 64'd0);
    send_cmd({iat_pkg::OP_MOV, 1'b0, iat_pkg::CLS_ALU}, 32'h8000_0000, iat_pkg::K_NUM, 0, 1,
             iat_pkg::K_NUM, 0, 1);
    send_cmd({iat_pkg::OP_ADD, 1'b1, iat_pkg::CLS_ALU64}, 0, iat_pkg::K_NUM, 1, 2,
             iat_pkg::K_NOINIT, 0, 1);
    send_cmd({iat_pkg::OP_ADD, 1'b1, iat_pkg::CLS_ALU64}, 0, 3'd5, 1, 2, iat_pkg::K_NUM, 0, 1);
    send_cmd({iat_pkg::OP_SUB, 1'b1, iat_pkg::CLS_ALU64}, 0, 3'd6, 1, 2, 3'd6, 0, 1);
    send_cmd({iat_pkg::OP_ADD, 1'b0, iat_pkg::CLS_ALU64}, 7, iat_pkg::K_UNKNOWN, 1, 2,
             iat_pkg::K_NUM, 0, 1);
    send_cmd({iat_pkg::OP_XOR, 1'b1, iat_pkg::CLS_ALU64}, 0, iat_pkg::K_NUM, 0, ALL1,
             iat_pkg::K_NUM, 0, ALL1);
    send_cmd({iat_pkg::OP_ADD, 1'b0, iat_pkg::CLS_ALU}, 32'hffff_ffff, iat_pkg::K_NUM,
             64'hffff_ffff, 64'h1_0000_0000, iat_pkg::K_NUM, 0, 0);
    // zero divisor, shift masking, byte order
    send_cmd({iat_pkg::OP_DIV, 1'b1, iat_pkg::CLS_ALU64}, 0, iat_pkg::K_NUM, 10, 14,
             iat_pkg::K_NUM, 0, 2);
    send_cmd({iat_pkg::OP_MOD, 1'b0, iat_pkg::CLS_ALU}, 0, iat_pkg::K_NUM, 64'h1_0000_0005,
             64'h1_0000_0006, iat_pkg::K_NUM, 0, 0);
    send_cmd({iat_pkg::OP_LSH, 1'b0, iat_pkg::CLS_ALU}, 33, iat_pkg::K_NUM, 1, 1,
             iat_pkg::K_NUM, 0, 0);
    send_cmd({iat_pkg::OP_ARSH, 1'b1, iat_pkg::CLS_ALU64}, 0, iat_pkg::K_NUM, ALL1 - 3, ALL1,
             iat_pkg::K_NUM, 64'd65, 64'd70);
    for (int k = 0; k < 4; k++)
      send_cmd({iat_pkg::OP_END, 1'($urandom()), iat_pkg::CLS_ALU}, swap_width(k),
               iat_pkg::K_NUM, 64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdf0,
               iat_pkg::K_NUM, 0, 0);
    send_cmd({iat_pkg::OP_NEG, 1'b0, iat_pkg::CLS_ALU}, 0, iat_pkg::K_NUM, 0, 1,
             iat_pkg::K_NUM, 0, 0);
  endtask

  task automatic test_random(input int count);
    logic [7:0] o;
    logic [63:0] dlo, dhi, slo, shi;
    logic [2:0] dk, sk;
    int span;
    repeat (count) begin
      o = rnd_op();
      span = (o[7:4] == iat_pkg::OP_MUL || o[7:4] == iat_pkg::OP_DIV
              || o[7:4] == iat_pkg::OP_MOD)
             ? (($urandom_range(0, 19) == 0) ? iat_pkg::SPAN_LIMIT_DEF : 3)
             : (($urandom_range(0, 3) == 0) ? 14 : iat_pkg::SPAN_LIMIT_DEF);
      rnd_interval(dlo, dhi, span);
      rnd_interval(slo, shi, span);
      dk = ($urandom_range(0, 3) != 0) ? iat_pkg::K_NUM : 3'($urandom());
      sk = ($urandom_range(0, 3) != 0) ? iat_pkg::K_NUM : 3'($urandom());
      send_cmd(o, rnd_imm(), dk, dlo, dhi, sk, slo, shi);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_every_opcode();
    test_bad_opcodes();
    test_special_cases();
    test_random(1950);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d transactions sent (%0d with bad opcodes), %0d results checked",
             n_sent, n_bad_sent, n_checked);
    if (n_errors == 0 && pending_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #400ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
